/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define SBT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Condition in one cycle implies the property in the next.
`define SBT_ASSERT_NEXT(lbl, clk, rst_n, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("%m: assertion failed");

`endif

/* hw/rtl/sbt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbt_pkg
// Types, codes and lookup functions of the source byte tokenizer.
// ----------------------------------------------------------------------------
package sbt_pkg;

  localparam int POS_BITS_DEF      = 16;
  localparam int KEYWORD_CHARS_DEF = 6;
  localparam int QUEUE_DEPTH       = 4;
  localparam int NUM_KW            = 14;

  typedef logic [5:0] kind_t;

  localparam kind_t K_ARROW    = 6'd15;
  localparam kind_t K_MINUS    = 6'd22;
  localparam kind_t K_CHAR     = 6'd23;
  localparam kind_t K_STR      = 6'd24;
  localparam kind_t K_IDENT    = 6'd25;
  localparam kind_t K_NUM      = 6'd26;
  localparam kind_t K_KW0      = 6'd27;
  localparam kind_t K_ERR      = 6'd41;
  localparam kind_t PUNCT_NONE = 6'h3F;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  typedef enum logic [2:0] {
    M_IDLE, M_MINUS, M_WORD, M_STR, M_CH1, M_CH2, M_HALT
  } lex_mode_e;

  typedef enum logic [3:0] {
    D_START, D_ZERO, D_DEC, D_DEC_E, D_DEC_X, D_ZX, D_HEX, D_HEX_P,
    D_HEX_X, D_INF, D_NAN, D_DEAD
  } dfa_e;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] row;
    logic [15:0] col;
    logic [15:0] len;
  } token_t;

  // Tokens caused by one byte: tok0 first, tok1 only when two is set.
  typedef struct packed {
    token_t tok0;
    token_t tok1;
    logic   two;
  } tok_pair_t;

  function automatic logic [47:0] kw_text(input int k);
    logic [47:0] t;
    case (k)
      0:       t = 48'h0000_0000_6E66;
      1:       t = 48'h0000_6D75_6E65;
      2:       t = 48'h7463_7572_7473;
      3:       t = 48'h0000_0000_6669;
      4:       t = 48'h0065_6C69_6877;
      5:       t = 48'h6E72_7574_6572;
      6:       t = 48'h006B_6165_7262;
      7:       t = 48'h0000_6575_7274;
      8:       t = 48'h0065_736C_6166;
      9:       t = 48'h0000_6573_6C65;
      10:      t = 48'h0000_0074_756D;
      11:      t = 48'h0000_6C6C_756E;
      12:      t = 48'h6863_7469_7773;
      13:      t = 48'h0000_6573_6163;
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [15:0] kw_len(input int k);
    logic [15:0] n;
    case (k)
      0, 3:             n = 16'd2;
      10:               n = 16'd3;
      1, 7, 9, 11, 13:  n = 16'd4;
      4, 6, 8:          n = 16'd5;
      2, 5, 12:         n = 16'd6;
      default:          n = 16'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    logic [7:0] l;
    l = to_lower(c);
    return is_dig(c) || (l >= 8'h61 && l <= 8'h66);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SP || c == CH_NL || c == CH_TAB || c == CH_CR;
  endfunction

  function automatic kind_t punct_code(input logic [7:0] c);
    kind_t p;
    case (c)
      8'h3A:   p = 6'd0;
      8'h23:   p = 6'd1;
      8'h3B:   p = 6'd2;
      8'h28:   p = 6'd3;
      8'h29:   p = 6'd4;
      8'h7B:   p = 6'd5;
      8'h7D:   p = 6'd6;
      8'h5B:   p = 6'd7;
      8'h5D:   p = 6'd8;
      8'h3D:   p = 6'd9;
      8'h21:   p = 6'd10;
      8'h25:   p = 6'd11;
      8'h2F:   p = 6'd12;
      8'h2C:   p = 6'd13;
      8'h7C:   p = 6'd14;
      8'h3E:   p = 6'd15;
      8'h3C:   p = 6'd16;
      8'h2A:   p = 6'd17;
      8'h26:   p = 6'd18;
      8'h2E:   p = 6'd19;
      8'h3F:   p = 6'd20;
      8'h2B:   p = 6'd21;
      8'h2D:   p = 6'd22;
      default: p = PUNCT_NONE;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] inf_char(input logic [2:0] i);
    logic [7:0] ch;
    case (i)
      3'd0:    ch = 8'h69;
      3'd1:    ch = 8'h6E;
      3'd2:    ch = 8'h66;
      3'd3:    ch = 8'h69;
      3'd4:    ch = 8'h6E;
      3'd5:    ch = 8'h69;
      3'd6:    ch = 8'h74;
      default: ch = 8'h79;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] nan_char(input logic [1:0] i);
    return (i == 2'd1) ? 8'h61 : 8'h6E;
  endfunction

  // Number recognizer step; idx is the position of c within the word.
  function automatic dfa_e dfa_next(input dfa_e s, input logic [7:0] c,
                                    input logic [15:0] idx);
    logic [7:0] l;
    dfa_e       n;
    l = to_lower(c);
    n = D_DEAD;
    case (s)
      D_START: begin
        if (c == 8'h30) n = D_ZERO;
        else if (is_dig(c)) n = D_DEC;
        else if (l == 8'h69) n = D_INF;
        else if (l == 8'h6E) n = D_NAN;
      end
      D_ZERO: begin
        if (is_dig(c)) n = D_DEC;
        else if (l == 8'h78) n = D_ZX;
        else if (l == 8'h65) n = D_DEC_E;
      end
      D_DEC: begin
        if (is_dig(c)) n = D_DEC;
        else if (l == 8'h65) n = D_DEC_E;
      end
      D_DEC_E, D_DEC_X: begin
        if (is_dig(c)) n = D_DEC_X;
      end
      D_ZX: begin
        if (is_hex(c)) n = D_HEX;
      end
      D_HEX: begin
        if (is_hex(c)) n = D_HEX;
        else if (l == 8'h70) n = D_HEX_P;
      end
      D_HEX_P, D_HEX_X: begin
        if (is_dig(c)) n = D_HEX_X;
      end
      D_INF: begin
        if (idx < 16'd8 && l == inf_char(idx[2:0])) n = D_INF;
      end
      D_NAN: begin
        if (idx < 16'd3 && l == nan_char(idx[1:0])) n = D_NAN;
      end
      default: n = D_DEAD;
    endcase
    return n;
  endfunction

  function automatic kind_t word_kind(input logic [47:0] prefix,
                                      input logic [15:0] len, input dfa_e s);
    kind_t k;
    logic  hit;
    hit = 1'b0;
    k   = K_IDENT;
    for (int i = 0; i < NUM_KW; i++) begin
      if (!hit && len == kw_len(i) && prefix == kw_text(i)) begin
        hit = 1'b1;
        k   = 6'(int'(K_KW0) + i);
      end
    end
    if (!hit) begin
      case (s)
        D_ZERO, D_DEC, D_DEC_X, D_HEX, D_HEX_X: k = K_NUM;
        D_INF:   k = (len == 16'd3 || len == 16'd8) ? K_NUM : K_IDENT;
        D_NAN:   k = (len == 16'd3) ? K_NUM : K_IDENT;
        default: k = K_IDENT;
      endcase
    end
    return k;
  endfunction

endpackage

/* hw/rtl/sbt_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbt_front
// Lexer front end: classifies each byte, tracks position and token state,
// and pushes the tokens each byte causes into the queue as one pair.
// ----------------------------------------------------------------------------
module sbt_front import sbt_pkg::*; #(
  parameter int POS_BITS      = POS_BITS_DEF,
  parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  input  logic       fin_i,
  output logic       push_o,
  output tok_pair_t  pair_o
);

  localparam int PW = KEYWORD_CHARS * 8;
  localparam logic [POS_BITS-1:0] POS_MAX = '1;
  localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

  lex_mode_e           mode_q, mode_d;
  logic [POS_BITS-1:0] row_q, row_d, col_q, col_d;
  logic [POS_BITS-1:0] srow_q, srow_d, scol_q, scol_d;
  logic [15:0]         len_q, len_d;
  logic [PW-1:0]       pre_q, pre_d;
  dfa_e                dfa_q, dfa_d;

  logic          blank, sep, redo, is_word, in_word;
  kind_t         pc;
  logic [PW-1:0] base_pre, add_pre, kw_pre;
  logic [15:0]   base_len, add_len, kw_len_s;
  dfa_e          base_dfa, add_dfa, kw_dfa;
  kind_t         wk;
  logic          a_v, b_v;
  token_t        tok_a, tok_b;
  lex_mode_e     idle_mode;

  function automatic logic [15:0] pos_out(input logic [POS_BITS-1:0] v);
    logic [POS_BITS+15:0] e;
    e = {16'd0, v};
    return (|e[POS_BITS+15:16]) ? 16'hFFFF : e[15:0];
  endfunction

  assign blank   = is_blank(byte_i);
  assign pc      = punct_code(byte_i);
  assign sep     = blank || byte_i == CH_SQ || byte_i == CH_DQ || pc != PUNCT_NONE;
  assign in_word = (mode_q == M_WORD);
  assign redo    = (mode_q == M_IDLE) || (mode_q == M_MINUS && byte_i != CH_GT)
                   || (in_word && sep);
  assign is_word = !sep;

  // Word accumulation, shared by a running word and a fresh one
  assign base_pre = in_word ? pre_q : '0;
  assign base_len = in_word ? len_q : 16'd0;
  assign base_dfa = in_word ? dfa_q : D_START;

  always_comb begin
    add_pre = base_pre;
    for (int i = 0; i < KEYWORD_CHARS; i++) begin
      if (base_len == 16'(i)) add_pre[i*8 +: 8] = byte_i;
    end
  end

  assign add_len  = (base_len == 16'hFFFF) ? base_len : base_len + 16'd1;
  assign add_dfa  = dfa_next(base_dfa, byte_i, base_len);
  assign kw_pre   = (in_word && sep) ? pre_q : add_pre;
  assign kw_len_s = (in_word && sep) ? len_q : add_len;
  assign kw_dfa   = (in_word && sep) ? dfa_q : add_dfa;
  assign wk       = word_kind(kw_pre[47:0], kw_len_s, kw_dfa);

  // Mode that a byte seen between tokens leaves behind
  always_comb begin
    if (blank) idle_mode = M_IDLE;
    else if (byte_i == CH_MINUS) idle_mode = M_MINUS;
    else if (byte_i == CH_SQ) idle_mode = M_CH1;
    else if (byte_i == CH_DQ) idle_mode = M_STR;
    else if (pc != PUNCT_NONE) idle_mode = M_IDLE;
    else idle_mode = M_WORD;
  end

  // Next state
  always_comb begin
    mode_d = mode_q;
    case (mode_q)
      M_IDLE, M_MINUS: mode_d = redo ? idle_mode : M_IDLE;
      M_WORD:          mode_d = sep ? idle_mode : M_WORD;
      M_STR:           mode_d = (byte_i == CH_DQ || fin_i) ? M_IDLE : M_STR;
      M_CH1:           mode_d = fin_i ? M_HALT : M_CH2;
      M_CH2:           mode_d = (byte_i == CH_SQ) ? M_IDLE : M_HALT;
      M_HALT:          mode_d = M_HALT;
      default:         mode_d = M_IDLE;
    endcase
    if (fin_i) mode_d = M_IDLE;
  end

  // Tokens and data registers
  always_comb begin
    a_v   = 1'b0;
    tok_a = '{kind: K_ERR, row: pos_out(srow_q), col: pos_out(scol_q), len: 16'd0};
    b_v   = 1'b0;
    tok_b = '{kind: pc, row: pos_out(row_q), col: pos_out(col_q), len: 16'd1};

    srow_d = srow_q;
    scol_d = scol_q;
    len_d  = len_q;
    pre_d  = pre_q;
    dfa_d  = dfa_q;

    case (mode_q)
      M_MINUS: begin
        a_v        = 1'b1;
        tok_a.kind = (byte_i == CH_GT) ? K_ARROW : K_MINUS;
        tok_a.len  = (byte_i == CH_GT) ? 16'd2 : 16'd1;
      end
      M_WORD: begin
        if (sep) begin
          a_v        = 1'b1;
          tok_a.kind = wk;
          tok_a.len  = len_q;
        end else begin
          pre_d = add_pre;
          len_d = add_len;
          dfa_d = add_dfa;
          if (fin_i) begin
            a_v        = 1'b1;
            tok_a.kind = wk;
            tok_a.len  = add_len;
          end
        end
      end
      M_STR: begin
        if (byte_i == CH_DQ || fin_i) begin
          a_v        = 1'b1;
          tok_a.kind = K_STR;
          tok_a.len  = (len_q == 16'hFFFF) ? len_q : len_q + 16'd1;
        end else if (len_q != 16'hFFFF) begin
          len_d = len_q + 16'd1;
        end
      end
      M_CH1: begin
        a_v = fin_i;
      end
      M_CH2: begin
        a_v = 1'b1;
        if (byte_i == CH_SQ) begin
          tok_a.kind = K_CHAR;
          tok_a.len  = 16'd1;
        end
      end
      default: a_v = 1'b0;
    endcase

    if (redo && !blank) begin
      srow_d = row_q;
      scol_d = col_q;
      len_d  = 16'd0;
      if (byte_i == CH_MINUS) begin
        b_v        = fin_i;
        tok_b.kind = K_MINUS;
      end else if (byte_i == CH_SQ) begin
        b_v        = fin_i;
        tok_b.kind = K_ERR;
        tok_b.len  = 16'd0;
      end else if (byte_i == CH_DQ) begin
        b_v        = fin_i;
        tok_b.kind = K_STR;
        tok_b.len  = 16'd0;
      end else if (pc != PUNCT_NONE) begin
        b_v = 1'b1;
      end else if (is_word) begin
        pre_d      = add_pre;
        len_d      = add_len;
        dfa_d      = add_dfa;
        b_v        = fin_i;
        tok_b.kind = wk;
        tok_b.len  = add_len;
      end
    end

    if (byte_i == CH_NL) begin
      row_d = (row_q == POS_MAX) ? row_q : row_q + POS_ONE;
      col_d = POS_ONE;
    end else begin
      row_d = row_q;
      col_d = (col_q == POS_MAX) ? col_q : col_q + POS_ONE;
    end

    // End of input: start over as after reset
    if (fin_i) begin
      row_d  = POS_ONE;
      col_d  = POS_ONE;
      srow_d = POS_ONE;
      scol_d = POS_ONE;
      len_d  = 16'd0;
      pre_d  = '0;
      dfa_d  = D_START;
    end
  end

  assign pair_o.tok0 = a_v ? tok_a : tok_b;
  assign pair_o.tok1 = tok_b;
  assign pair_o.two  = a_v && b_v;
  assign push_o      = accept_i && (a_v || b_v);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      row_q  <= POS_ONE;
      col_q  <= POS_ONE;
      srow_q <= POS_ONE;
      scol_q <= POS_ONE;
      len_q  <= 16'd0;
      pre_q  <= '0;
      dfa_q  <= D_START;
    end else if (accept_i) begin
      mode_q <= mode_d;
      row_q  <= row_d;
      col_q  <= col_d;
      srow_q <= srow_d;
      scol_q <= scol_d;
      len_q  <= len_d;
      pre_q  <= pre_d;
      dfa_q  <= dfa_d;
    end
  end

endmodule

/* hw/rtl/sbt_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbt_queue
// Short queue of token pairs between the lexer front end and the output.
// ----------------------------------------------------------------------------
module sbt_queue import sbt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  tok_pair_t pair_i,
  output logic      ready_o,
  input  logic      pop_i,
  output tok_pair_t head_o,
  output logic      nonempty_o
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  tok_pair_t     mem_q [QUEUE_DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]   cnt_q, cnt_d;

  assign ready_o    = cnt_q != (AW+1)'(QUEUE_DEPTH);
  assign nonempty_o = cnt_q != '0;
  assign head_o     = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) wr_d = (wr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    if (pop_i) rd_d = (rd_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= pair_i;
  end

endmodule

/* hw/rtl/sbt_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbt_back
// Output stage: holds one token pair and hands its tokens out one at a time.
// ----------------------------------------------------------------------------
module sbt_back import sbt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  tok_pair_t head_i,
  input  logic      nonempty_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output token_t    tok_o,
  output logic      last_o
);

  tok_pair_t pair_q;
  logic      valid_q, valid_d, sel_q, sel_d;
  logic      fire;

  assign tok_o       = sel_q ? pair_q.tok1 : pair_q.tok0;
  assign last_o      = sel_q || !pair_q.two;
  assign out_valid_o = valid_q;
  assign fire        = valid_q && out_ready_i;
  assign pop_o       = nonempty_i && (!valid_q || (fire && last_o));

  always_comb begin
    valid_d = valid_q;
    sel_d   = sel_q;
    if (pop_o) begin
      valid_d = 1'b1;
      sel_d   = 1'b0;
    end else if (fire) begin
      // advance to the second token, or drop the finished pair
      valid_d = !last_o;
      sel_d   = !last_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sel_q   <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) pair_q <= head_i;
  end

endmodule

/* hw/rtl/source_byte_tokenizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_byte_tokenizer
// Streaming lexer: source bytes in, tokens (kind, row, column, length) out.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  in       in   in_valid_i/in_ready_o  source_byte_i, final_byte_i
//  out      out  out_valid_o/out_ready_i token_kind_o, token_row_o,
//                                       token_col_o, token_length_o,
//                                       last_of_run_o
//
// One byte is taken per cycle while the queue has room; the front end finishes
// a byte in the cycle it is accepted. A token passes the queue, then the
// output register, which sends one token per cycle while out_ready_i is high.
// A byte causing two tokens sends both; the 4-entry queue absorbs this.
// in_ready_o falls only when the queue is full. Reset needs no clearing pass.
// ----------------------------------------------------------------------------
module source_byte_tokenizer import sbt_pkg::*; #(
  parameter int POS_BITS      = POS_BITS_DEF,
  parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  source_byte_i,
  input  logic        final_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  token_kind_o,
  output logic [15:0] token_row_o,
  output logic [15:0] token_col_o,
  output logic [15:0] token_length_o,
  output logic        last_of_run_o
);

  logic      push, pop, nonempty, accept;
  tok_pair_t pair, head;
  token_t    tok;

  assign accept = in_valid_i && in_ready_o;

  sbt_front #(
    .POS_BITS      (POS_BITS),
    .KEYWORD_CHARS (KEYWORD_CHARS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (source_byte_i),
    .fin_i    (final_byte_i),
    .push_o   (push),
    .pair_o   (pair)
  );

  sbt_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .pair_i     (pair),
    .ready_o    (in_ready_o),
    .pop_i      (pop),
    .head_o     (head),
    .nonempty_o (nonempty)
  );

  sbt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .nonempty_i  (nonempty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .tok_o       (tok),
    .last_o      (last_of_run_o)
  );

  assign token_kind_o   = tok.kind;
  assign token_row_o    = tok.row;
  assign token_col_o    = tok.col;
  assign token_length_o = tok.len;

endmodule

/* hw/rtl/sbt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbt_checker
// Port-level checks on the tokenizer output, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbt_checker import sbt_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [5:0]  token_kind_o,
  input logic [15:0] token_row_o,
  input logic [15:0] token_col_o,
  input logic [15:0] token_length_o,
  input logic        last_of_run_o
);

  logic        out_stall, punct_kind;
  logic [54:0] out_word;

  assign out_stall  = out_valid_o && !out_ready_i;
  assign punct_kind = token_kind_o <= K_MINUS && token_kind_o != K_ARROW;
  assign out_word   = {token_kind_o, token_row_o, token_col_o, token_length_o, last_of_run_o};

  `SBT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_word))
  `SBT_ASSERT(a_pos_nonzero, clk_i, rst_ni, out_valid_o |-> |token_row_o && |token_col_o)
  `SBT_ASSERT(a_kind_range, clk_i, rst_ni, out_valid_o |-> token_kind_o <= K_ERR)
  `SBT_ASSERT(a_punct_len, clk_i, rst_ni, out_valid_o && punct_kind |-> token_length_o == 16'd1)
  `SBT_ASSERT(a_err_len, clk_i, rst_ni, out_valid_o && token_kind_o == K_ERR |-> token_length_o == 16'd0)

endmodule

bind source_byte_tokenizer sbt_checker u_sbt_checker (.*);

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for source_byte_tokenizer: a directed byte table, then
// random token streams. A behavioral lexer predicts every token, and the
// output side checks them in order.
// ----------------------------------------------------------------------------
module tb;
  import sbt_pkg::*;

  localparam kind_t KIND_LPAREN = 6'd3;
  localparam kind_t NO_CHECK    = PUNCT_NONE;
  localparam int    STALL_LIMIT = 2000;
  localparam logic [15:0] SAT = 16'hFFFF;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] row;
    logic [15:0] col;
    logic [15:0] len;
    logic        last;
  } tok_s;

  typedef struct packed {
    logic [7:0]  b;
    logic        fin;
    kind_t       kind;
    logic [15:0] len;
  } dir_row_s;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  source_byte_i = 8'h00;
  logic        final_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [5:0]  token_kind_o;
  logic [15:0] token_row_o;
  logic [15:0] token_col_o;
  logic [15:0] token_length_o;
  logic        last_of_run_o;

  source_byte_tokenizer uut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Lexer state mirror
  lex_mode_e   lx_mode;
  dfa_e        lx_num;
  logic [15:0] lx_row, lx_col, lx_srow, lx_scol, lx_len;
  logic [47:0] lx_prefix;

  tok_s  byte_toks[$];
  tok_s  expected_toks[$];
  int    errors = 0;
  int    items = 0;
  bit    quiet = 1'b1;
  bit    drained = 1'b0;
  int    stall_left = 0;
  int    idle_cycles = 0;

  string kw_words[14] = '{"fn", "enum", "struct", "if", "while", "return", "break",
                          "true", "false", "else", "mut", "null", "switch", "case"};
  string punct_chars = ":#;(){}[]=!%/,|><*&.?+-";
  string hex_chars = "0123456789abcdefABCDEF";
  string word_chars = "abcdefghijklmnopqrstuvwxyz_0123456789";
  string inf_word = "infinity";
  string nan_word = "nan";

  function automatic int punct_of(logic [7:0] c);
    for (int i = 0; i < punct_chars.len(); i++)
      if (punct_chars[i] == c) return i;
    return -1;
  endfunction

  function automatic bit blank(logic [7:0] c);
    return c == CH_SP || c == CH_NL || c == CH_TAB || c == CH_CR;
  endfunction

  function automatic bit ends_word(logic [7:0] c);
    return blank(c) || c == CH_SQ || c == CH_DQ || punct_of(c) >= 0;
  endfunction

  function automatic logic [7:0] lc(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic bit digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit hexdig(logic [7:0] c);
    return digit(c) || (lc(c) >= "a" && lc(c) <= "f");
  endfunction

  function automatic dfa_e number_step(dfa_e s, logic [7:0] c, logic [15:0] idx);
    logic [7:0] l;
    l = lc(c);
    case (s)
      D_START: begin
        if (c == "0") return D_ZERO;
        if (digit(c)) return D_DEC;
        if (l == "i") return D_INF;
        if (l == "n") return D_NAN;
        return D_DEAD;
      end
      D_ZERO: begin
        if (digit(c)) return D_DEC;
        if (l == "x") return D_ZX;
        if (l == "e") return D_DEC_E;
        return D_DEAD;
      end
      D_DEC: begin
        if (digit(c)) return D_DEC;
        return (l == "e") ? D_DEC_E : D_DEAD;
      end
      D_DEC_E, D_DEC_X: return digit(c) ? D_DEC_X : D_DEAD;
      D_ZX: return hexdig(c) ? D_HEX : D_DEAD;
      D_HEX: begin
        if (hexdig(c)) return D_HEX;
        return (l == "p") ? D_HEX_P : D_DEAD;
      end
      D_HEX_P, D_HEX_X: return digit(c) ? D_HEX_X : D_DEAD;
      D_INF: return (idx < 8 && l == inf_word[idx]) ? D_INF : D_DEAD;
      D_NAN: return (idx < 3 && l == nan_word[idx]) ? D_NAN : D_DEAD;
      default: return D_DEAD;
    endcase
  endfunction

  function automatic kind_t classify_word();
    bit hit;
    for (int k = 0; k < 14; k++) begin
      if (lx_len != kw_words[k].len()) continue;
      hit = 1'b1;
      for (int i = 0; i < kw_words[k].len(); i++)
        if (lx_prefix[8*i +: 8] != kw_words[k][i]) hit = 1'b0;
      if (hit) return kind_t'(K_KW0 + k);
    end
    case (lx_num)
      D_ZERO, D_DEC, D_DEC_X, D_HEX, D_HEX_X: return K_NUM;
      D_INF: return (lx_len == 3 || lx_len == 8) ? K_NUM : K_IDENT;
      D_NAN: return (lx_len == 3) ? K_NUM : K_IDENT;
      default: return K_IDENT;
    endcase
  endfunction

  function automatic void lexer_clear();
    lx_mode = M_IDLE;
    lx_num = D_START;
    lx_row = 16'd1;
    lx_col = 16'd1;
    lx_srow = 16'd1;
    lx_scol = 16'd1;
    lx_len = 16'd0;
    lx_prefix = '0;
  endfunction

  function automatic void token_out(kind_t k, logic [15:0] r, logic [15:0] c,
                                    logic [15:0] n);
    byte_toks.push_back('{k, r, c, n, 1'b0});
  endfunction

  function automatic void word_append(logic [7:0] c);
    if (lx_len < 6) lx_prefix[8*lx_len +: 8] = c;
    lx_num = number_step(lx_num, c, lx_len);
    if (lx_len != SAT) lx_len++;
  endfunction

  function automatic void token_begin(logic [7:0] c, logic fin);
    int p;
    lx_mode = M_IDLE;
    if (blank(c)) return;
    lx_srow = lx_row;
    lx_scol = lx_col;
    lx_len = 16'd0;
    p = punct_of(c);
    if (c == CH_MINUS) begin
      if (fin) token_out(K_MINUS, lx_row, lx_col, 16'd1);
      else lx_mode = M_MINUS;
    end else if (c == CH_SQ) begin
      if (fin) token_out(K_ERR, lx_row, lx_col, 16'd0);
      else lx_mode = M_CH1;
    end else if (c == CH_DQ) begin
      if (fin) token_out(K_STR, lx_row, lx_col, 16'd0);
      else lx_mode = M_STR;
    end else if (p >= 0) begin
      token_out(kind_t'(p), lx_row, lx_col, 16'd1);
    end else begin
      lx_prefix = '0;
      lx_num = D_START;
      word_append(c);
      if (fin) token_out(classify_word(), lx_row, lx_col, lx_len);
      else lx_mode = M_WORD;
    end
  endfunction

  // Work out the tokens one byte causes into byte_toks.
  function automatic void lex_byte(logic [7:0] c, logic fin);
    bit redo;
    redo = 1'b0;
    byte_toks.delete();
    case (lx_mode)
      M_MINUS: begin
        lx_mode = M_IDLE;
        if (c == CH_GT) token_out(K_ARROW, lx_srow, lx_scol, 16'd2);
        else begin
          token_out(K_MINUS, lx_srow, lx_scol, 16'd1);
          redo = 1'b1;
        end
      end
      M_WORD: begin
        if (ends_word(c)) begin
          token_out(classify_word(), lx_srow, lx_scol, lx_len);
          redo = 1'b1;
        end else begin
          word_append(c);
          if (fin) token_out(classify_word(), lx_srow, lx_scol, lx_len);
        end
      end
      M_STR: begin
        if (c == CH_DQ || fin) begin
          token_out(K_STR, lx_srow, lx_scol, (lx_len == SAT) ? SAT : lx_len + 16'd1);
          lx_mode = M_IDLE;
        end else if (lx_len != SAT) lx_len++;
      end
      M_CH1: begin
        if (fin) begin
          token_out(K_ERR, lx_srow, lx_scol, 16'd0);
          lx_mode = M_HALT;
        end else lx_mode = M_CH2;
      end
      M_CH2: begin
        if (c == CH_SQ) begin
          token_out(K_CHAR, lx_srow, lx_scol, 16'd1);
          lx_mode = M_IDLE;
        end else begin
          token_out(K_ERR, lx_srow, lx_scol, 16'd0);
          lx_mode = M_HALT;
        end
      end
      M_HALT: ;
      default: redo = 1'b1;
    endcase
    if (redo) token_begin(c, fin);
    if (c == CH_NL) begin
      if (lx_row != SAT) lx_row++;
      lx_col = 16'd1;
    end else if (lx_col != SAT) lx_col++;
    if (byte_toks.size() > 0) byte_toks[byte_toks.size()-1].last = 1'b1;
    if (fin) lexer_clear();
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drive one byte, wait for its transaction, then predict.
  task automatic feed(input logic [7:0] b, input logic fin,
                      input kind_t k = NO_CHECK, input logic [15:0] n = 16'd0);
    int g;
    g = gap_len();
    if (g > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (g - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    source_byte_i = b;
    final_byte_i = fin;
    do @(posedge clk_i); while (!in_ready_o);
    lex_byte(b, fin);
    if (k != NO_CHECK) begin
      byte_toks[0].kind = k;
      byte_toks[0].len = n;
    end
    foreach (byte_toks[i]) expected_toks.push_back(byte_toks[i]);
    items++;
  endtask

  task automatic put(input logic [7:0] b);
    feed(b, $urandom_range(0, 39) == 0);
  endtask

  task automatic put_word(input string s, input bit mix);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mix && c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - 8'd32;
      put(c);
    end
  endtask

  task automatic random_fragment();
    string ws;
    ws = " \t\r\n";
    case ($urandom_range(0, 9))
      0: put_word(kw_words[$urandom_range(0, 13)], $urandom_range(0, 7) == 0);
      1: begin
        case ($urandom_range(0, 2))
          0: begin
            repeat ($urandom_range(1, 4)) put("0" + $urandom_range(0, 9));
            if ($urandom_range(0, 1)) begin
              put($urandom_range(0, 1) ? "e" : "E");
              repeat ($urandom_range(0, 3)) put("0" + $urandom_range(0, 9));
            end
          end
          1: begin
            put("0");
            put($urandom_range(0, 1) ? "x" : "X");
            repeat ($urandom_range(0, 4)) put(hex_chars[$urandom_range(0, 21)]);
            if ($urandom_range(0, 1)) begin
              put($urandom_range(0, 1) ? "p" : "P");
              repeat ($urandom_range(0, 3)) put("0" + $urandom_range(0, 9));
            end
          end
          default: begin
            case ($urandom_range(0, 2))
              0: put_word("inf", 1'b1);
              1: put_word(inf_word.substr(0, $urandom_range(1, 7)), 1'b1);
              default: put_word(nan_word, 1'b1);
            endcase
          end
        endcase
        if ($urandom_range(0, 7) == 0) put("g");
      end
      2: repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(0, 3) == 0) put($urandom_range(0, 255));
        else put(word_chars[$urandom_range(0, 36)]);
      end
      3: put(punct_chars[$urandom_range(0, punct_chars.len() - 1)]);
      4: begin
        put(CH_MINUS);
        put(CH_GT);
      end
      5: begin
        put(CH_SQ);
        put($urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0) put($urandom_range(0, 255));
        else put(CH_SQ);
      end
      6: begin
        put(CH_DQ);
        repeat ($urandom_range(0, 10)) put($urandom_range(0, 255));
        if ($urandom_range(0, 5) != 0) put(CH_DQ);
      end
      7, 8: put(ws[$urandom_range(0, 3)]);
      default: put($urandom_range(0, 255));
    endcase
  endtask

  dir_row_s directed[] = '{
    '{"(", 1'b0, KIND_LPAREN, 16'd1},
    '{"-", 1'b0, NO_CHECK, 16'd0},
    '{">", 1'b0, K_ARROW, 16'd2},
    '{"-", 1'b0, NO_CHECK, 16'd0},
    '{"x", 1'b0, K_MINUS, 16'd1},
    '{" ", 1'b0, NO_CHECK, 16'd0},
    '{CH_SQ, 1'b0, NO_CHECK, 16'd0},
    '{8'hFF, 1'b0, NO_CHECK, 16'd0},
    '{CH_SQ, 1'b0, K_CHAR, 16'd1},
    '{CH_DQ, 1'b0, NO_CHECK, 16'd0},
    '{8'h00, 1'b0, NO_CHECK, 16'd0},
    '{CH_DQ, 1'b0, K_STR, 16'd2},
    '{CH_NL, 1'b0, NO_CHECK, 16'd0},
    '{"f", 1'b0, NO_CHECK, 16'd0},
    '{"n", 1'b0, NO_CHECK, 16'd0},
    '{CH_TAB, 1'b0, NO_CHECK, 16'd0},
    '{"0", 1'b0, NO_CHECK, 16'd0},
    '{"x", 1'b0, NO_CHECK, 16'd0},
    '{"F", 1'b0, NO_CHECK, 16'd0},
    '{"p", 1'b0, NO_CHECK, 16'd0},
    '{";", 1'b0, NO_CHECK, 16'd0},
    '{CH_SQ, 1'b0, NO_CHECK, 16'd0},
    '{"a", 1'b0, NO_CHECK, 16'd0},
    '{"b", 1'b0, K_ERR, 16'd0},
    '{CH_DQ, 1'b1, NO_CHECK, 16'd0},
    '{"N", 1'b0, NO_CHECK, 16'd0},
    '{"a", 1'b0, NO_CHECK, 16'd0},
    '{"n", 1'b1, NO_CHECK, 16'd0}
  };

  // Output side: random back-pressure, then check each transaction.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i = 1'b0;
      stall_left--;
    end else if (rst_ni && !quiet && $urandom_range(0, 9) == 0) begin
      out_ready_i = 1'b0;
      stall_left = $urandom_range(0, 3) == 0 ? $urandom_range(10, 40) : $urandom_range(0, 2);
    end else begin
      out_ready_i = rst_ni;
    end
  end

  always @(posedge clk_i) begin
    tok_s got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{token_kind_o, token_row_o, token_col_o, token_length_o, last_of_run_o};
      if (expected_toks.size() == 0) begin
        errors++;
        $display("%0t: unexpected token kind %0d row %0d col %0d len %0d last %0b",
                 $time, got.kind, got.row, got.col, got.len, got.last);
      end else begin
        want = expected_toks.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: token mismatch expected kind %0d row %0d col %0d len %0d last %0b",
                   $time, want.kind, want.row, want.col, want.len, want.last);
          $display("%0t:                  actual kind %0d row %0d col %0d len %0d last %0b",
                   $time, got.kind, got.row, got.col, got.len, got.last);
        end
      end
    end
  end

  // Watchdog: too long with no transaction on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      idle_cycles = 0;
    else if (++idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    lexer_clear();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i])
      feed(directed[i].b, directed[i].fin, directed[i].kind, directed[i].len);

    // First stretch of random traffic with no idling, then with gaps.
    items = 0;
    while (items < 850) begin
      if (items > 120) quiet = 1'b0;
      random_fragment();
      if (!drained && items > 400) begin
        // hold until every token is out
        @(negedge clk_i);
        in_valid_i = 1'b0;
        while (expected_toks.size() != 0) @(posedge clk_i);
        drained = 1'b1;
      end
    end
    feed(" ", 1'b1);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_toks.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
